// ----- design/sha256c_pkg.sv -----
// Package with shared types, constants and round functions of the SHA-256 compression engine.
package sha256c_pkg;

  localparam int WordW   = 32;
  localparam int ChainN  = 8;
  localparam int BlockN  = 16;
  localparam int Rounds  = 64;
  localparam int CountW  = 64;
  localparam int CfgIdxW = 4;
  localparam int BlockBytes = BlockN * WordW / 8;

  typedef logic [WordW-1:0]            word_t;
  typedef word_t [ChainN-1:0]          chain_t;
  typedef logic [$clog2(Rounds)-1:0]   round_idx_t;
  typedef logic [$clog2(ChainN)-1:0]   word_idx_t;
  typedef logic [$clog2(BlockN)-1:0]   word_pos_t;
  typedef logic [CountW-1:0]           count_t;
  typedef logic [CfgIdxW-1:0]          cfg_idx_t;

  localparam logic ReqWord    = 1'b0;
  localparam logic ReqRestart = 1'b1;

  // Element 0 is the rightmost entry of the packed literal.
  localparam chain_t InitReset = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic load_init;
    logic load_work;
    logic round_en;
    logic final_add;
  } core_ctl_t;

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ----- design/sha256c_if.sv -----
// Channel interfaces for message input, digest output and configuration writes.
interface sha256c_in_if;
  import sha256c_pkg::*;
  logic  valid;
  logic  ready;
  logic  req_type;
  word_t msg_word;
  modport source(output valid, req_type, msg_word, input ready);
  modport sink(input valid, req_type, msg_word, output ready);
endinterface

interface sha256c_out_if;
  import sha256c_pkg::*;
  logic      valid;
  logic      ready;
  word_t     digest_word;
  word_idx_t word_index;
  logic      last;
  count_t    bytes_done;
  modport source(output valid, digest_word, word_index, last, bytes_done, input ready);
  modport sink(input valid, digest_word, word_index, last, bytes_done, output ready);
endinterface

interface sha256c_cfg_if;
  import sha256c_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- design/sha256c_sched.sv -----
// Message schedule window that collects the block and expands one word per round.
module sha256c_sched (
  input  logic               clk,
  input  logic               shift_in,
  input  logic               round_en,
  input  sha256c_pkg::word_t msg_word,
  output sha256c_pkg::word_t w_t
);
  import sha256c_pkg::*;

  word_t win [BlockN];
  word_t w_new;

  assign w_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  assign w_t   = win[0];

  always_ff @(posedge clk) begin
    if (shift_in || round_en) begin
      for (int i = 0; i < BlockN - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BlockN-1] <= shift_in ? msg_word : w_new;
    end
  end

endmodule

// ----- design/sha256c_core.sv -----
// Round datapath with working variables and the chaining state.
module sha256c_core (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256c_pkg::core_ctl_t ctl,
  input  sha256c_pkg::chain_t    init_words,
  input  sha256c_pkg::word_t     w_t,
  input  sha256c_pkg::word_t     k_t,
  output sha256c_pkg::chain_t    chain
);
  import sha256c_pkg::*;

  chain_t work;
  word_t  t1;
  word_t  t2;
  word_t  choose;
  word_t  major;

  assign choose = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign major  = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1     = work[7] + big_sigma1(work[4]) + choose + k_t + w_t;
  assign t2     = big_sigma0(work[0]) + major;

  always_ff @(posedge clk) begin
    if (ctl.load_work) begin
      work <= chain;
    end else if (ctl.round_en) begin
      work[7] <= work[6];
      work[6] <= work[5];
      work[5] <= work[4];
      work[4] <= work[3] + t1;
      work[3] <= work[2];
      work[2] <= work[1];
      work[1] <= work[0];
      work[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= InitReset;
    end else if (ctl.load_init) begin
      chain <= init_words;
    end else if (ctl.final_add) begin
      for (int i = 0; i < ChainN; i++) begin
        chain[i] <= chain[i] + work[i];
      end
    end
  end

endmodule

// ----- design/sha256c_ctrl.sv -----
// Sequencer that steers word collection, the round loop and digest output.
module sha256c_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_req_type,
  input  logic                    out_ready,
  output logic                    in_ready,
  output logic                    out_valid,
  output logic                    shift_in,
  output sha256c_pkg::core_ctl_t  ctl,
  output sha256c_pkg::round_idx_t rnd,
  output sha256c_pkg::word_idx_t  oidx,
  output sha256c_pkg::count_t     bytes
);
  import sha256c_pkg::*;

  typedef enum logic [1:0] {StIdle, StRound, StFinal, StOut} state_t;

  state_t    state;
  word_pos_t wpos;
  logic      in_acc;

  assign in_ready      = (state == StIdle);
  assign out_valid     = (state == StOut);
  assign in_acc        = in_valid && in_ready;
  assign shift_in      = in_acc && (in_req_type == ReqWord);
  assign ctl.load_init = in_acc && (in_req_type == ReqRestart);
  assign ctl.load_work = shift_in && (wpos == word_pos_t'(BlockN - 1));
  assign ctl.round_en  = (state == StRound);
  assign ctl.final_add = (state == StFinal);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      wpos  <= '0;
      rnd   <= '0;
      oidx  <= '0;
      bytes <= '0;
    end else begin
      unique case (state)
        StIdle: begin
          if (ctl.load_init) begin
            wpos  <= '0;
            bytes <= '0;
          end else if (shift_in) begin
            wpos <= wpos + word_pos_t'(1);
            if (ctl.load_work) begin
              rnd   <= '0;
              state <= StRound;
            end
          end
        end
        StRound: begin
          rnd <= rnd + round_idx_t'(1);
          if (rnd == round_idx_t'(Rounds - 1)) begin
            state <= StFinal;
          end
        end
        StFinal: begin
          bytes <= bytes + count_t'(BlockBytes);
          oidx  <= '0;
          state <= StOut;
        end
        StOut: begin
          if (out_ready) begin
            oidx <= oidx + word_idx_t'(1);
            if (oidx == word_idx_t'(ChainN - 1)) begin
              state <= StIdle;
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

endmodule

// ----- design/sha256_block_compress_top.sv -----
// SHA-256 block compression engine: top level with configuration registers and output channel.
// Words one to fifteen of a block and restart transactions are accepted while the engine is idle.
// The sixteenth word starts the rounds on the shared round unit, then the add into the
// chaining state, then eight output transactions, one per cycle while the sink is ready.
// Synchronous reset restores the standard initial values, clears the byte count and position.
module sha256_block_compress_top (
  input logic          clk,
  input logic          rst,
  sha256c_in_if.sink   in_ch,
  sha256c_out_if.source out_ch,
  sha256c_cfg_if.sink  cfg_ch
);
  import sha256c_pkg::*;

  chain_t     init_words;
  chain_t     chain;
  core_ctl_t  ctl;
  round_idx_t rnd;
  word_idx_t  oidx;
  count_t     bytes;
  word_t      w_t;
  logic       shift_in;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_words <= InitReset;
    end else if (cfg_ch.valid && (cfg_ch.index < cfg_idx_t'(ChainN))) begin
      init_words[cfg_ch.index[$clog2(ChainN)-1:0]] <= cfg_ch.data;
    end
  end

  sha256c_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .out_ready   (out_ch.ready),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .shift_in    (shift_in),
    .ctl         (ctl),
    .rnd         (rnd),
    .oidx        (oidx),
    .bytes       (bytes)
  );

  sha256c_sched u_sched (
    .clk      (clk),
    .shift_in (shift_in),
    .round_en (ctl.round_en),
    .msg_word (in_ch.msg_word),
    .w_t      (w_t)
  );

  sha256c_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .init_words (init_words),
    .w_t        (w_t),
    .k_t        (RoundK[rnd]),
    .chain      (chain)
  );

  assign out_ch.digest_word = chain[oidx];
  assign out_ch.word_index  = oidx;
  assign out_ch.last        = (oidx == word_idx_t'(ChainN - 1));
  assign out_ch.bytes_done  = bytes;

endmodule
